// File: src/abas_pkg.sv
// ----------------------------------------------------------------------------
// abas_pkg
// Shared types and constants of the ADC block average scaler.
// ----------------------------------------------------------------------------
package abas_pkg;

  localparam int DEFAULT_SAMPLE_BITS = 12;

  localparam int SUM_BITS       = 20;
  localparam int COUNT_BITS     = 8;
  localparam int FS_BITS        = 12;
  localparam int REF_BITS       = 13;
  localparam int MV_BITS        = 16;
  localparam int PCT_BITS       = 8;
  localparam int PCT_SCALE_BITS = 7;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int STEP_BITS      = $clog2(SUM_BITS);

  localparam logic [PCT_SCALE_BITS-1:0] PERCENT_SCALE = 7'd100;

  localparam logic [COUNT_BITS-1:0] BLOCK_SIZE_RESET = 8'd16;
  localparam logic [FS_BITS-1:0]    FULL_SCALE_RESET = 12'd4095;
  localparam logic [REF_BITS-1:0]   REF_MV_RESET     = 13'd3300;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BLOCK_SIZE = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_REF_MV     = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_MULT,
    ST_SCALE_LOAD,
    ST_SCALE_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mult;
    logic scale_load;
    logic scale_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic result_due;
    logic zero_result;
  } status_t;

endpackage

// File: src/adc_block_average_scaler.sv
// ----------------------------------------------------------------------------
// adc_block_average_scaler
// Boxcar average decimator with millivolt and percent scaling.
// ----------------------------------------------------------------------------
// Each sample is taken while the block is idle and added to the block
// accumulator. The sample that closes a block starts the result
// computation: a restoring division of the sum by the sample count, a
// multiplication, a range check, and a restoring division by the
// full-scale code shared in step by the millivolt and percent lanes, then
// a load of the result register. The input is ready again once the result
// register is loaded, with the divisions skipped when the block size is
// zero, provided the previous result has been taken by then. The result
// register stays valid until taken while new samples are accumulated.
// Configuration writes are meant for an idle block.
module adc_block_average_scaler #(
  parameter int SAMPLE_BITS = abas_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // average, millivolts, percent
  output logic [((SAMPLE_BITS + abas_pkg::MV_BITS + abas_pkg::PCT_BITS + 7) / 8) * 8 - 1:0]
                                                  m_tdata,
  input  logic                                    cfg_we,
  input  logic [abas_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [abas_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import abas_pkg::*;

  localparam int OUT_BITS   = SAMPLE_BITS + MV_BITS + PCT_BITS;
  localparam int M_BITS     = ((OUT_BITS + 7) / 8) * 8;

  cmd_t                   cmd;
  status_t                status;
  logic [SAMPLE_BITS-1:0] average;
  logic [MV_BITS-1:0]     millivolts;
  logic [PCT_BITS-1:0]    percent;

  abas_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  abas_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (s_tdata[SAMPLE_BITS-1:0]),
    .cmd        (cmd),
    .status     (status),
    .average    (average),
    .millivolts (millivolts),
    .percent    (percent)
  );

  assign m_tdata = M_BITS'({percent, millivolts, average});

endmodule

// File: src/abas_scale_lane.sv
// ----------------------------------------------------------------------------
// abas_scale_lane
// Restoring divider for a scaled average, one quotient bit per cycle while
// step is high, with a saturation flag when the quotient would not fit in MV_BITS.
// ----------------------------------------------------------------------------
module abas_scale_lane #(
  parameter int DIVIDEND_BITS = 28
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic                              step,
  input  logic [DIVIDEND_BITS-1:0]          dividend,
  input  logic [abas_pkg::FS_BITS-1:0]      divisor,
  output logic [abas_pkg::MV_BITS-1:0]      quotient,
  output logic                              sat
);
  import abas_pkg::*;

  logic [FS_BITS-1:0]     rem;
  logic [MV_BITS-1:0]     quo;
  logic [DIVIDEND_BITS-1:0] limit;
  logic [FS_BITS:0]       trial;
  logic [FS_BITS:0]       diff;
  logic                   ge;

  assign limit = DIVIDEND_BITS'({divisor, {MV_BITS{1'b0}}});
  assign trial = {rem, quo[MV_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  // The upper part of the dividend is already below the divisor when the
  // quotient fits, so MV_BITS steps finish the division.
  always_ff @(posedge clk) begin
    if (load) begin
      sat <= dividend >= limit;
      rem <= dividend[MV_BITS +: FS_BITS];
      quo <= dividend[MV_BITS-1:0];
    end else if (step) begin
      rem <= ge ? diff[FS_BITS-1:0] : trial[FS_BITS-1:0];
      quo <= {quo[MV_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: src/abas_datapath.sv
// ----------------------------------------------------------------------------
// abas_datapath
// Accumulator, configuration registers, average divider, scaling
// multipliers and dividers, and the result register.
// ----------------------------------------------------------------------------
module abas_datapath #(
  parameter int SAMPLE_BITS = abas_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [abas_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [abas_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [SAMPLE_BITS-1:0]                sample,
  input  abas_pkg::cmd_t                        cmd,
  output abas_pkg::status_t                     status,
  output logic [SAMPLE_BITS-1:0]                average,
  output logic [abas_pkg::MV_BITS-1:0]          millivolts,
  output logic [abas_pkg::PCT_BITS-1:0]         percent
);
  import abas_pkg::*;

  localparam int MV_PROD_BITS  = SAMPLE_BITS + REF_BITS;
  localparam int PCT_PROD_BITS = SAMPLE_BITS + PCT_SCALE_BITS;
  localparam int EXT_BITS      = (MV_PROD_BITS > MV_BITS + FS_BITS) ?
                                 MV_PROD_BITS : MV_BITS + FS_BITS;

  logic [COUNT_BITS-1:0] block_size;
  logic [FS_BITS-1:0]    adc_full_scale;
  logic [REF_BITS-1:0]   reference_millivolts;

  logic [SUM_BITS-1:0]   sum_of_samples;
  logic [COUNT_BITS-1:0] samples_taken;
  logic                  add_sample;
  logic [SUM_BITS-1:0]   sum_acc;
  logic [COUNT_BITS-1:0] taken_acc;

  logic [SUM_BITS-1:0]   div_quo;
  logic [COUNT_BITS-1:0] div_rem;
  logic [COUNT_BITS-1:0] div_den;
  logic [COUNT_BITS:0]   div_trial;
  logic [COUNT_BITS:0]   div_diff;
  logic                  div_ge;
  logic                  zero_res;

  logic [MV_PROD_BITS-1:0]  mv_prod;
  logic [PCT_PROD_BITS-1:0] pct_prod;
  logic [MV_BITS-1:0]       mv_quo;
  logic [MV_BITS-1:0]       pct_quo;
  logic                     mv_sat;
  logic                     pct_sat;
  logic [SAMPLE_BITS-1:0]   avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size           <= BLOCK_SIZE_RESET;
      adc_full_scale       <= FULL_SCALE_RESET;
      reference_millivolts <= REF_MV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size           <= cfg_data[COUNT_BITS-1:0];
        CFG_FULL_SCALE: adc_full_scale       <= cfg_data[FS_BITS-1:0];
        CFG_REF_MV:     reference_millivolts <= cfg_data[REF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A sample is only added while the block is still short; a block size
  // lowered to or under the count closes the block without the new sample.
  assign add_sample = samples_taken < block_size;
  assign sum_acc    = add_sample ? sum_of_samples + SUM_BITS'(sample) : sum_of_samples;
  assign taken_acc  = add_sample ? samples_taken + 1'b1 : samples_taken;

  assign status.result_due  = taken_acc >= block_size;
  assign status.zero_result = taken_acc == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_of_samples <= '0;
      samples_taken  <= '0;
    end else if (cmd.accept) begin
      if (status.result_due) begin
        sum_of_samples <= '0;
        samples_taken  <= '0;
      end else begin
        sum_of_samples <= sum_acc;
        samples_taken  <= taken_acc;
      end
    end
  end

  assign div_trial = {div_rem, div_quo[SUM_BITS-1]};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign avg       = div_quo[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_quo  <= sum_acc;
      div_rem  <= '0;
      div_den  <= taken_acc;
      zero_res <= status.zero_result;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
      div_quo <= {div_quo[SUM_BITS-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      mv_prod  <= avg * reference_millivolts;
      pct_prod <= avg * PERCENT_SCALE;
    end
  end

  abas_scale_lane #(
    .DIVIDEND_BITS(EXT_BITS)
  ) u_mv_lane (
    .clk      (clk),
    .load     (cmd.scale_load),
    .step     (cmd.scale_step),
    .dividend (EXT_BITS'(mv_prod)),
    .divisor  (adc_full_scale),
    .quotient (mv_quo),
    .sat      (mv_sat)
  );

  abas_scale_lane #(
    .DIVIDEND_BITS(EXT_BITS)
  ) u_pct_lane (
    .clk      (clk),
    .load     (cmd.scale_load),
    .step     (cmd.scale_step),
    .dividend (EXT_BITS'(pct_prod)),
    .divisor  (adc_full_scale),
    .quotient (pct_quo),
    .sat      (pct_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (zero_res) begin
        average    <= '0;
        millivolts <= '0;
        percent    <= '0;
      end else begin
        average    <= avg;
        millivolts <= mv_sat ? {MV_BITS{1'b1}} : mv_quo;
        percent    <= (pct_sat || (|pct_quo[MV_BITS-1:PCT_BITS])) ?
                      {PCT_BITS{1'b1}} : pct_quo[PCT_BITS-1:0];
      end
    end
  end

endmodule

// File: src/abas_controller.sv
// ----------------------------------------------------------------------------
// abas_controller
// Sequencer for sample intake, the average and scaling divisions, and the
// result handshake.
// ----------------------------------------------------------------------------
module abas_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  abas_pkg::status_t  status,
  output abas_pkg::cmd_t     cmd
);
  import abas_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] cnt;
  logic [STEP_BITS-1:0] cnt_next;
  logic                 out_valid;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.result_due) begin
            state_next = status.zero_result ? ST_DONE : ST_AVG_DIV;
          end
        end
      end
      ST_AVG_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(SUM_BITS - 1)) begin
          cnt_next   = '0;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_SCALE_LOAD;
      end
      ST_SCALE_LOAD: begin
        cmd.scale_load = 1'b1;
        state_next     = ST_SCALE_DIV;
      end
      ST_SCALE_DIV: begin
        cmd.scale_step = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt == STEP_BITS'(MV_BITS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait for the result register to empty before overwriting it.
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
    out_valid_next = cmd.out_load ? 1'b1 : (out_valid && !m_tready);
  end

  assign m_tvalid = out_valid;

endmodule

// File: src/abas_checker.sv
// ----------------------------------------------------------------------------
// abas_checker
// Port-level checks of the ADC block average scaler, bound to the top level.
// ----------------------------------------------------------------------------
module abas_checker #(
  parameter int SAMPLE_BITS = abas_pkg::DEFAULT_SAMPLE_BITS
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    s_tvalid,
  input logic                                    s_tready,
  input logic                                    m_tvalid,
  input logic                                    m_tready,
  input logic [((SAMPLE_BITS + abas_pkg::MV_BITS + abas_pkg::PCT_BITS + 7) / 8) * 8 - 1:0]
                                                 m_tdata
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // A new result only appears at the end of a computation, during which
  // samples are refused.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a preceding computation");

  // Reset leaves the block ready for samples with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // The block is never busy with no work: refusing samples follows either
  // an accepted sample or an earlier refusal.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !$past(rst) |-> $past(s_tvalid && s_tready) || !$past(s_tready))
    else $error("input refused without an accepted sample");

endmodule

bind adc_block_average_scaler abas_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_abas_checker (.*);
